[rtl/wpbc_pkg.sv]
// wpbc_pkg: shared constants, register map and configuration struct for the
// windowed pid balance controller. No dependencies; every other rtl file
// depends on it.
`default_nettype none

package wpbc_pkg;

   // default field widths of the sample and integral paths
   localparam int DEF_SAMPLE_WIDTH   = 16;
   localparam int DEF_INTEGRAL_WIDTH = 32;

   // fixed widths
   localparam int GAIN_WIDTH  = 11;
   localparam int LIMIT_WIDTH = 16;
   localparam int CMD_WIDTH   = 24;

   // register port geometry: five 32-bit registers at 4-byte spacing
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_LSB  = 2;

   typedef enum logic [2:0] {
      REG_GAIN_PROP    = 3'd0,
      REG_GAIN_INTEG   = 3'd1,
      REG_GAIN_DERIV   = 3'd2,
      REG_TARGET_PITCH = 3'd3,
      REG_ERROR_LIMIT  = 3'd4
   } reg_index_type;

   // reset values; the error limit is about 1.50781 rad in Q4.12
   localparam logic [GAIN_WIDTH-1:0]  RST_GAIN_PROP   = 11'h7EC;  // -20
   localparam logic [GAIN_WIDTH-1:0]  RST_GAIN_INTEG  = 11'h7FB;  // -5
   localparam logic [GAIN_WIDTH-1:0]  RST_GAIN_DERIV  = 11'h7FF;  // -1
   localparam logic [LIMIT_WIDTH-1:0] RST_ERROR_LIMIT = 16'd6176;

   // gains and window bound, as seen by the datapath
   typedef struct packed {
      logic [GAIN_WIDTH-1:0]  gain_prop;
      logic [GAIN_WIDTH-1:0]  gain_integ;
      logic [GAIN_WIDTH-1:0]  gain_deriv;
      logic [LIMIT_WIDTH-1:0] error_limit;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/wpbc_req_if.sv]
// wpbc_req_if: valid/ready channel carrying one pitch sample per beat.
// Depends on wpbc_pkg for the default sample width.
`default_nettype none

interface wpbc_req_if #(
   parameter int SAMPLE_WIDTH = wpbc_pkg::DEF_SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] pitch_sample;

   modport source (output valid, output pitch_sample, input ready);
   modport sink   (input valid, input pitch_sample, output ready);
endinterface

`default_nettype wire

[rtl/wpbc_rsp_if.sv]
// wpbc_rsp_if: valid/ready channel carrying one speed command per beat.
// Depends on wpbc_pkg for the command width.
`default_nettype none

interface wpbc_rsp_if;
   import wpbc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [CMD_WIDTH-1:0] speed_command;
   logic                        correcting;

   modport source (output valid, output speed_command, output correcting, input ready);
   modport sink   (input valid, input speed_command, input correcting, output ready);
endinterface

`default_nettype wire

[rtl/wpbc_csr.sv]
// wpbc_csr: APB-style register file for gains, target pitch and error limit.
// Depends on wpbc_pkg for the register map, reset values and cfg_type.
`default_nettype none

module wpbc_csr #(
   parameter int SAMPLE_WIDTH = wpbc_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wpbc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [wpbc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wpbc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output wpbc_pkg::cfg_type                   cfg,
   output logic signed [SAMPLE_WIDTH-1:0]      target_pitch
);
   import wpbc_pkg::*;

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic [SAMPLE_WIDTH-1:0]  target_ff;
   logic [SAMPLE_WIDTH-1:0]  target_in;
   logic                     wr_en;
   reg_index_type            index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[CSR_INDEX_LSB +: 3]);

   // write decode; addresses past the last register are dropped
   always_comb begin
      cfg_in    = cfg_ff;
      target_in = target_ff;
      if (wr_en) begin
         unique case (index)
            REG_GAIN_PROP:    cfg_in.gain_prop   = csr_pwdata[GAIN_WIDTH-1:0];
            REG_GAIN_INTEG:   cfg_in.gain_integ  = csr_pwdata[GAIN_WIDTH-1:0];
            REG_GAIN_DERIV:   cfg_in.gain_deriv  = csr_pwdata[GAIN_WIDTH-1:0];
            REG_TARGET_PITCH: target_in          = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_ERROR_LIMIT:  cfg_in.error_limit = csr_pwdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop   <= RST_GAIN_PROP;
         cfg_ff.gain_integ  <= RST_GAIN_INTEG;
         cfg_ff.gain_deriv  <= RST_GAIN_DERIV;
         cfg_ff.error_limit <= RST_ERROR_LIMIT;
         target_ff          <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         target_ff <= target_in;
      end
   end

   // read mux, signed registers sign-extended to the bus
   always_comb begin
      unique case (index)
         REG_GAIN_PROP:    csr_prdata = CSR_DATA_WIDTH'($signed(cfg_ff.gain_prop));
         REG_GAIN_INTEG:   csr_prdata = CSR_DATA_WIDTH'($signed(cfg_ff.gain_integ));
         REG_GAIN_DERIV:   csr_prdata = CSR_DATA_WIDTH'($signed(cfg_ff.gain_deriv));
         REG_TARGET_PITCH: csr_prdata = CSR_DATA_WIDTH'($signed(target_ff));
         REG_ERROR_LIMIT:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.error_limit);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg          = cfg_ff;
   assign target_pitch = $signed(target_ff);

endmodule

`default_nettype wire

[rtl/wpbc_error_stage.sv]
// wpbc_error_stage: error, saturating integral, difference and window test.
// Holds the controller state; depends on wpbc_pkg for the limit width.
`default_nettype none

module wpbc_error_stage #(
   parameter int SAMPLE_WIDTH   = wpbc_pkg::DEF_SAMPLE_WIDTH,
   parameter int INTEGRAL_WIDTH = wpbc_pkg::DEF_INTEGRAL_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic signed [SAMPLE_WIDTH-1:0]         pitch_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]         target_pitch,
   input  logic [wpbc_pkg::LIMIT_WIDTH-1:0]       error_limit,
   output logic signed [SAMPLE_WIDTH:0]           error_out,
   output logic signed [INTEGRAL_WIDTH-1:0]       integral_out,
   output logic signed [SAMPLE_WIDTH+1:0]         diff_out,
   output logic                                   active_out
);
   import wpbc_pkg::*;

   localparam int EW = SAMPLE_WIDTH + 1;
   localparam int DW = SAMPLE_WIDTH + 2;
   localparam int AW = ((INTEGRAL_WIDTH > EW) ? INTEGRAL_WIDTH : EW) + 1;
   localparam int CW = (EW > LIMIT_WIDTH) ? EW : LIMIT_WIDTH;
   localparam logic signed [AW-1:0] IMAX =
      {{(AW-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] IMIN = ~IMAX;

   logic signed [INTEGRAL_WIDTH-1:0] integral_ff;
   logic signed [INTEGRAL_WIDTH-1:0] integral_in;
   logic signed [EW-1:0]             prev_error_ff;
   logic signed [DW-1:0]             diff_ff;
   logic signed [DW-1:0]             diff_in;
   logic                             active_ff;
   logic                             active_in;
   logic signed [EW-1:0]             error;
   logic signed [AW-1:0]             integral_sum;
   logic [EW-1:0]                    magnitude;

   // error is one bit wider than the sample, so it never wraps
   assign error = EW'(target_pitch) - EW'(pitch_sample);

   // saturating accumulate
   assign integral_sum = AW'(integral_ff) + AW'(error);
   always_comb begin
      if (integral_sum > IMAX) begin
         integral_in = IMAX[INTEGRAL_WIDTH-1:0];
      end else if (integral_sum < IMIN) begin
         integral_in = IMIN[INTEGRAL_WIDTH-1:0];
      end else begin
         integral_in = integral_sum[INTEGRAL_WIDTH-1:0];
      end
   end

   assign diff_in = DW'(error) - DW'(prev_error_ff);

   // window: 0 < |error| < limit
   assign magnitude = error[EW-1] ? EW'(-error) : EW'(error);
   assign active_in = (magnitude != '0) && (CW'(magnitude) < CW'(error_limit));

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         prev_error_ff <= '0;
      end else if (load) begin
         integral_ff   <= integral_in;
         prev_error_ff <= error;
      end
   end

   // per-item terms for the product stage
   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff   <= diff_in;
         active_ff <= active_in;
      end
   end

   assign error_out    = prev_error_ff;
   assign integral_out = integral_ff;
   assign diff_out     = diff_ff;
   assign active_out   = active_ff;

endmodule

`default_nettype wire

[rtl/wpbc_mix.sv]
// wpbc_mix: three gain products, sum, 24-bit saturation and window gating.
// Depends on wpbc_pkg for gain and command widths and cfg_type.
`default_nettype none

module wpbc_mix #(
   parameter int SAMPLE_WIDTH   = wpbc_pkg::DEF_SAMPLE_WIDTH,
   parameter int INTEGRAL_WIDTH = wpbc_pkg::DEF_INTEGRAL_WIDTH
) (
   input  wpbc_pkg::cfg_type                        cfg,
   input  logic signed [SAMPLE_WIDTH:0]             error,
   input  logic signed [INTEGRAL_WIDTH-1:0]         integral,
   input  logic signed [SAMPLE_WIDTH+1:0]           diff,
   input  logic                                     active,
   output logic signed [wpbc_pkg::CMD_WIDTH-1:0]    speed_command
);
   import wpbc_pkg::*;

   localparam int EW   = SAMPLE_WIDTH + 1;
   localparam int DW   = SAMPLE_WIDTH + 2;
   localparam int PW   = GAIN_WIDTH + ((INTEGRAL_WIDTH > DW) ? INTEGRAL_WIDTH : DW);
   localparam int SUMW = PW + 2;
   localparam logic signed [SUMW-1:0] CMAX =
      {{(SUMW-CMD_WIDTH+1){1'b0}}, {(CMD_WIDTH-1){1'b1}}};
   localparam logic signed [SUMW-1:0] CMIN = ~CMAX;

   logic signed [GAIN_WIDTH+EW-1:0]             prod_prop;
   logic signed [GAIN_WIDTH+INTEGRAL_WIDTH-1:0] prod_integ;
   logic signed [GAIN_WIDTH+DW-1:0]             prod_deriv;
   logic signed [SUMW-1:0]                      sum;
   logic signed [CMD_WIDTH-1:0]                 sat;

   // three independent products
   assign prod_prop  = $signed(cfg.gain_prop)  * error;
   assign prod_integ = $signed(cfg.gain_integ) * integral;
   assign prod_deriv = $signed(cfg.gain_deriv) * diff;

   assign sum = SUMW'(prod_prop) + SUMW'(prod_integ) + SUMW'(prod_deriv);

   // clamp to the command range
   always_comb begin
      if (sum > CMAX) begin
         sat = CMAX[CMD_WIDTH-1:0];
      end else if (sum < CMIN) begin
         sat = CMIN[CMD_WIDTH-1:0];
      end else begin
         sat = sum[CMD_WIDTH-1:0];
      end
   end

   assign speed_command = active ? sat : '0;

endmodule

`default_nettype wire

[rtl/windowed_pid_balance_controller_unit.sv]
// windowed_pid_balance_controller_unit: top level of the windowed pid controller.
// Depends on wpbc_pkg, wpbc_req_if, wpbc_rsp_if, wpbc_csr, wpbc_error_stage and wpbc_mix.
//
//   port       dir   width         carries
//   req_chan   in    SAMPLE_WIDTH  pitch_sample, one per beat
//   rsp_chan   out   24 + 1        speed_command, correcting, one per beat
//   csr_*      in    32            apb-style register writes and reads
//
// one beat per cycle sustained while rsp_chan is ready; a result is offered once its sample has passed
// the input register, the error/integral register and the result register; the product stage sets
// the longest path.
// reset clears the integral, previous error, all valid flags and loads register defaults.
// each stage has its own ready, so samples keep entering while a result waits on rsp_chan, until every stage is full.
`default_nettype none

module windowed_pid_balance_controller_unit #(
   parameter int SAMPLE_WIDTH   = wpbc_pkg::DEF_SAMPLE_WIDTH,
   parameter int INTEGRAL_WIDTH = wpbc_pkg::DEF_INTEGRAL_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   wpbc_req_if.sink                            req_chan,
   wpbc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wpbc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [wpbc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [wpbc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import wpbc_pkg::*;

   cfg_type                          cfg;
   logic signed [SAMPLE_WIDTH-1:0]   target_pitch;
   logic signed [SAMPLE_WIDTH-1:0]   pitch_ff;
   logic signed [SAMPLE_WIDTH:0]     error;
   logic signed [INTEGRAL_WIDTH-1:0] integral;
   logic signed [SAMPLE_WIDTH+1:0]   diff;
   logic                             active;
   logic signed [CMD_WIDTH-1:0]      cmd_in;
   logic signed [CMD_WIDTH-1:0]      cmd_ff;
   logic                             corr_ff;
   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic                             mid_valid_ff;
   logic                             mid_valid_in;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic                             out_ready;
   logic                             mid_ready;
   logic                             in_ready;
   logic                             take;
   logic                             move_in;
   logic                             move_mid;

   wpbc_csr #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .cfg          (cfg),
      .target_pitch (target_pitch)
   );

   // per-stage flow control
   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign in_ready  = !in_valid_ff || mid_ready;
   assign take      = req_chan.valid && in_ready;
   assign move_in   = in_valid_ff && mid_ready;
   assign move_mid  = mid_valid_ff && out_ready;

   assign req_chan.ready = in_ready;

   always_comb begin
      in_valid_in  = take ? 1'b1 : (move_in ? 1'b0 : in_valid_ff);
      mid_valid_in = move_in ? 1'b1 : (move_mid ? 1'b0 : mid_valid_ff);
      out_valid_in = move_mid ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (take) begin
         pitch_ff <= req_chan.pitch_sample;
      end
   end

   wpbc_error_stage #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_error_stage (
      .clock        (clock),
      .reset        (reset),
      .load         (move_in),
      .pitch_sample (pitch_ff),
      .target_pitch (target_pitch),
      .error_limit  (cfg.error_limit),
      .error_out    (error),
      .integral_out (integral),
      .diff_out     (diff),
      .active_out   (active)
   );

   wpbc_mix #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_mix (
      .cfg           (cfg),
      .error         (error),
      .integral      (integral),
      .diff          (diff),
      .active        (active),
      .speed_command (cmd_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (move_mid) begin
         cmd_ff  <= cmd_in;
         corr_ff <= active;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.speed_command = cmd_ff;
   assign rsp_chan.correcting    = corr_ff;

   // a result outside the window carries a zero command
   a_closed_window_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.correcting |-> rsp_chan.speed_command == '0)
      else $error("nonzero command outside the window");

   // a full, stalled pipeline takes no sample
   a_full_no_take: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && mid_valid_ff && out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("sample taken while pipeline full");

   // a taken sample sits in the input register next cycle
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> in_valid_ff)
      else $error("taken sample lost");

   // the result register is held while the beat is stalled
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(cmd_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire

[tb/tb_windowed_pid_balance_controller_unit.sv]
`timescale 1ns / 100ps
// tb_windowed_pid_balance_controller_unit: self-checking bench for the windowed pid unit.
// Depends on wpbc_pkg, wpbc_req_if, wpbc_rsp_if and windowed_pid_balance_controller_unit.
// Directed table, random rounds under idle/stall mixes, then a short integral wind-up run.

module tb_windowed_pid_balance_controller_unit;
   import wpbc_pkg::*;

   localparam int     SW              = 16;
   localparam int     HALF_PERIOD     = 6;
   localparam int     DRAIN_CYCLES    = 5;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam int     ROUNDS          = 11;
   localparam int     ROUND_ITEMS     = 90;
   localparam int     PRESSURE_ROUND  = 4;
   localparam int     SOAK_ITEMS      = 10;
   localparam longint INTEG_MAX       = 64'sd2147483647;
   localparam longint INTEG_MIN       = -64'sd2147483648;
   localparam longint CMD_MAX         = 64'sd8388607;
   localparam longint CMD_MIN         = -64'sd8388608;
   localparam logic [2:0] REG_UNUSED_5 = 3'd5;
   localparam logic [2:0] REG_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic signed [CMD_WIDTH-1:0] speed_command;
      logic                        correcting;
   } speed_result_t;

   typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

   typedef struct {
      row_kind_t                   kind;
      logic [2:0]                  reg_sel;
      logic [31:0]                 wdata;
      logic signed [SW-1:0]        pitch;
      bit                          typed;
      logic signed [CMD_WIDTH-1:0] cmd;
      bit                          corr;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   wpbc_req_if #(.SAMPLE_WIDTH(SW)) req_chan ();
   wpbc_rsp_if rsp_chan ();

   windowed_pid_balance_controller_unit #(
      .SAMPLE_WIDTH   (SW),
      .INTEGRAL_WIDTH (32)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // controller settings and state as the bench sees them
   logic signed [GAIN_WIDTH-1:0]  kp;
   logic signed [GAIN_WIDTH-1:0]  ki;
   logic signed [GAIN_WIDTH-1:0]  kd;
   logic signed [SW-1:0]          set_point;
   logic        [LIMIT_WIDTH-1:0] window_limit;
   longint                        integ_sum;
   longint                        last_error;

   speed_result_t pending_commands[$];
   int            fail_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_off_seq = 0;
   int            hold_off_seen = 0;
   int            hold_off_left = 0;

   // directed stimulus; expected values typed only where obvious
   directed_row_t directed_rows [33] = '{
      // reset settings: first sample from cleared state, zero error, far outside
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd1,      1'b1, 24'sd26, 1'b1},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0,      1'b1, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sh7FFF,   1'b1, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sh8000,   1'b1, 24'sd0,  1'b0},
      // error equal to the limit is outside, one below is inside
      '{ROW_SAMPLE, 3'd0, 32'd0, -16'sd6176,  1'b1, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, -16'sd6175,  1'b0, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd6175,   1'b0, 24'sd0,  1'b0},
      // max gains, widest error, positive overflow
      '{ROW_WRITE, REG_GAIN_PROP,    32'd1023,  16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_INTEG,   32'd1023,  16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_DERIV,   32'd1023,  16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_TARGET_PITCH, 32'd32767, 16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_ERROR_LIMIT,  32'd65535, 16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, -16'sd32767, 1'b0, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sh8000,   1'b1, 24'sd0,  1'b0},
      // min gains, widest negative error, positive overflow
      '{ROW_WRITE, REG_GAIN_PROP,    -32'sd1024,  16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_INTEG,   -32'sd1024,  16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_DERIV,   -32'sd1024,  16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_TARGET_PITCH, -32'sd32768, 16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd32767,  1'b1, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd32766,  1'b0, 24'sd0,  1'b0},
      // writes past the last register must not land anywhere
      '{ROW_WRITE, REG_UNUSED_5, 32'd0,        16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_UNUSED_7, 32'hFFFF_FFFF, 16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0,      1'b0, 24'sd0,  1'b0},
      // zero limit closes the window
      '{ROW_WRITE, REG_ERROR_LIMIT,  32'd0,     16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd5,      1'b1, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, -16'sd5,     1'b1, 24'sd0,  1'b0},
      // limit one: nothing passes; limit two: magnitude one passes
      '{ROW_WRITE, REG_TARGET_PITCH, 32'd0,     16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_WRITE, REG_ERROR_LIMIT,  32'd1,     16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0,      1'b1, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd1,      1'b1, 24'sd0,  1'b0},
      '{ROW_WRITE, REG_ERROR_LIMIT,  32'd2,     16'sd0, 1'b0, 24'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd1,      1'b0, 24'sd0,  1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, -16'sd1,     1'b0, 24'sd0,  1'b0}
   };

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the controller state by one sample and return its command
   function automatic speed_result_t predict_command(input logic signed [SW-1:0] pitch);
      longint        err;
      longint        diff;
      longint        total;
      longint        mag;
      speed_result_t r;
      err        = longint'(set_point) - longint'(pitch);
      integ_sum  = clamp_range(integ_sum + err, INTEG_MIN, INTEG_MAX);
      diff       = err - last_error;
      last_error = err;
      total = longint'(kp) * err + longint'(ki) * integ_sum + longint'(kd) * diff;
      total = clamp_range(total, CMD_MIN, CMD_MAX);
      mag   = (err < 0) ? -err : err;
      r.correcting    = (mag > 0) && (mag < longint'(window_limit));
      r.speed_command = r.correcting ? total[CMD_WIDTH-1:0] : '0;
      return r;
   endfunction

   function automatic void apply_setting(input logic [2:0] sel, input logic [31:0] data);
      case (sel)
         REG_GAIN_PROP:    kp           = data[GAIN_WIDTH-1:0];
         REG_GAIN_INTEG:   ki           = data[GAIN_WIDTH-1:0];
         REG_GAIN_DERIV:   kd           = data[GAIN_WIDTH-1:0];
         REG_TARGET_PITCH: set_point    = data[SW-1:0];
         REG_ERROR_LIMIT:  window_limit = data[LIMIT_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [2:0] sel, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      apply_setting(sel, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one sample, with random idle beats ahead of it
   task automatic send_sample(input logic signed [SW-1:0] pitch, input bit typed,
                              input logic signed [CMD_WIDTH-1:0] cmd, input bit corr);
      speed_result_t predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid        <= 1'b0;
         req_chan.pitch_sample <= SW'($urandom);
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.pitch_sample <= pitch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_command(pitch);
      if (typed)
         pending_commands.push_back('{cmd, corr});
      else
         pending_commands.push_back(predicted);
   endtask

   // stop offering and let every outstanding command come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      int g;
      case ($urandom_range(5))
         0: g = -1024;
         1: g = 1023;
         2, 3: g = int'($urandom_range(32)) - 16;
         default: g = int'($urandom_range(2047)) - 1024;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd65535;
         2: return $urandom_range(16);
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic logic [31:0] pick_target();
      case ($urandom_range(7))
         0: return -32'sd32768;
         1: return 32'd32767;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   // mostly errors spread up to the window limit, some small or zero errors and raw noise
   function automatic logic signed [SW-1:0] pick_pitch();
      int off;
      int p;
      case ($urandom_range(7))
         0: return SW'($urandom);
         1: return set_point;
         2: off = $urandom_range(3);
         default: off = $urandom_range(int'(window_limit));
      endcase
      if ($urandom_range(1)) off = -off;
      p = int'(set_point) - off;
      if (p < -32768 || p > 32767) p = $urandom;
      return p[SW-1:0];
   endfunction

   // fixed error run at one pitch to wind the integral up and back
   task automatic soak_integral(input logic signed [SW-1:0] pitch, input int count);
      repeat (count) send_sample(pitch, 1'b0, '0, 1'b0);
   endtask

   // result receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_seq != hold_off_seen) begin
         hold_off_seen  <= hold_off_seq;
         hold_off_left  <= HOLD_OFF_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left  <= hold_off_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      speed_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_commands.size() == 0) begin
            $error("unexpected result beat: speed_command %0d, correcting %0b",
                   rsp_chan.speed_command, rsp_chan.correcting);
            fail_count++;
         end else begin
            want = pending_commands.pop_front();
            if (rsp_chan.speed_command !== want.speed_command) begin
               $error("speed_command mismatch: expected %0d, actual %0d",
                      want.speed_command, rsp_chan.speed_command);
               fail_count++;
            end
            if (rsp_chan.correcting !== want.correcting) begin
               $error("correcting mismatch: expected %0b, actual %0b",
                      want.correcting, rsp_chan.correcting);
               fail_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #12_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // main sequence
   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.pitch_sample = '0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      kp           = RST_GAIN_PROP;
      ki           = RST_GAIN_INTEG;
      kd           = RST_GAIN_DERIV;
      set_point    = '0;
      window_limit = RST_ERROR_LIMIT;
      integ_sum    = 0;
      last_error   = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_drained();
            csr_write(directed_rows[i].reg_sel, directed_rows[i].wdata);
         end else begin
            send_sample(directed_rows[i].pitch, directed_rows[i].typed,
                        directed_rows[i].cmd, directed_rows[i].corr);
         end
      end
      wait_drained();

      // random rounds, each with fresh settings and its own idle mix
      for (int round = 0; round < ROUNDS; round++) begin
         csr_write(REG_GAIN_PROP, pick_gain());
         csr_write(REG_GAIN_INTEG, pick_gain());
         csr_write(REG_GAIN_DERIV, pick_gain());
         csr_write(REG_TARGET_PITCH, pick_target());
         csr_write(REG_ERROR_LIMIT, pick_limit());
         case (round % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            if (round == PRESSURE_ROUND && n == 20)
               hold_off_seq <= hold_off_seq + 1;
            if (round == PRESSURE_ROUND && n == 60)
               wait_drained();
            send_sample(pick_pitch(), 1'b0, '0, 1'b0);
         end
         wait_drained();
      end

      // integral wind-up: unit integral gain, error just inside the widest window
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      csr_write(REG_GAIN_PROP, 32'd0);
      csr_write(REG_GAIN_INTEG, 32'd1);
      csr_write(REG_GAIN_DERIV, 32'd0);
      csr_write(REG_ERROR_LIMIT, 32'd65535);
      csr_write(REG_TARGET_PITCH, 32'd32767);
      soak_integral(-16'sd32767, SOAK_ITEMS);
      wait_drained();
      csr_write(REG_TARGET_PITCH, -32'sd32767);
      soak_integral(16'sd32767, 2 * SOAK_ITEMS);
      wait_drained();
      csr_write(REG_TARGET_PITCH, 32'd32767);
      soak_integral(-16'sd32767, SOAK_ITEMS);
      wait_drained();

      if (pending_commands.size() != 0) begin
         $error("%0d expected results never arrived", pending_commands.size());
      end
      if (fail_count == 0 && pending_commands.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
